>>> design/urlpc_pkg.sv
// Shared types, constants and character-class functions for the URL percent codec.
package urlpc_pkg;

    localparam logic [1:0] MODE_DECODE   = 2'd0;
    localparam logic [1:0] MODE_ENC_ALL  = 2'd1;
    localparam logic [1:0] MODE_ENC_PATH = 2'd2;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // One classified input item: up to three bytes to emit.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      last_idx;
        logic            str_last;
    } urlpc_job_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
               ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_path_safe(input logic [7:0] c);
        return (c == 8'h2f) || (c == 8'h24) || (c == 8'h2d) || (c == 8'h5f) ||
               (c == 8'h2e) || (c == 8'h2b) || (c == 8'h21) || (c == 8'h2a) ||
               (c == 8'h27) || (c == 8'h28) || (c == 8'h29);
    endfunction

    // Letters of either case land on low nibble 1..6, so add 9.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

>>> design/urlpc_front.sv
// Front end: mode register, escape tracking and classification of each input byte.
module urlpc_front
    import urlpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       q_full,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    output logic       q_push,
    output urlpc_job_t q_data
);

    logic [1:0] mode_reg;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [7:0] held_dig_reg, held_dig_next;
    logic       accept;
    logic [1:0] n;
    logic       keep;

    assign accept = push && !q_full;

    always_comb
    begin
        held_cnt_next   = held_cnt_reg;
        held_dig_next   = held_dig_reg;
        q_data          = '0;
        n               = 2'd0;
        keep            = 1'b0;
        q_data.str_last = string_last;
        if (mode_reg == MODE_DECODE)
        begin
            unique case (held_cnt_reg)
                HELD_NONE:
                begin
                    if (in_byte == PCT_CHAR)
                        held_cnt_next = HELD_PCT;
                    else
                    begin
                        q_data.data[n] = in_byte;
                        n = n + 2'd1;
                    end
                end
                HELD_PCT:
                begin
                    if (is_hex(in_byte))
                    begin
                        held_cnt_next = HELD_DIGIT;
                        held_dig_next = in_byte;
                    end
                    else
                    begin
                        q_data.data[n] = PCT_CHAR;
                        n = n + 2'd1;
                        if (in_byte == PCT_CHAR)
                            held_cnt_next = HELD_PCT;
                        else
                        begin
                            held_cnt_next  = HELD_NONE;
                            q_data.data[n] = in_byte;
                            n = n + 2'd1;
                        end
                    end
                end
                default:
                begin
                    if (is_hex(in_byte))
                    begin
                        held_cnt_next  = HELD_NONE;
                        q_data.data[n] = {hex_val(held_dig_reg), hex_val(in_byte)};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        q_data.data[n] = PCT_CHAR;
                        n = n + 2'd1;
                        q_data.data[n] = held_dig_reg;
                        n = n + 2'd1;
                        if (in_byte == PCT_CHAR)
                            held_cnt_next = HELD_PCT;
                        else
                        begin
                            held_cnt_next  = HELD_NONE;
                            q_data.data[n] = in_byte;
                            n = n + 2'd1;
                        end
                    end
                end
            endcase
            // end of string flushes whatever is still held
            if (string_last)
            begin
                if (held_cnt_next != HELD_NONE)
                begin
                    q_data.data[n] = PCT_CHAR;
                    n = n + 2'd1;
                end
                if (held_cnt_next == HELD_DIGIT)
                begin
                    q_data.data[n] = held_dig_next;
                    n = n + 2'd1;
                end
                held_cnt_next = HELD_NONE;
            end
        end
        else
        begin
            keep = is_alnum(in_byte) || ((mode_reg == MODE_ENC_PATH) && is_path_safe(in_byte));
            held_cnt_next = HELD_NONE;
            if (keep)
            begin
                q_data.data[0] = in_byte;
                n = 2'd1;
            end
            else
            begin
                q_data.data[0] = PCT_CHAR;
                q_data.data[1] = HEX_UPPER[in_byte[7:4]];
                q_data.data[2] = HEX_UPPER[in_byte[3:0]];
                n = 2'd3;
            end
        end
        q_data.last_idx = n - 2'd1;
    end

    // items that only add to the held escape make no queue entry
    assign q_push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_DECODE;
            held_cnt_reg <= HELD_NONE;
            held_dig_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg     <= cfg_wr_data;
            held_cnt_reg <= HELD_NONE;
        end
        else if (accept)
        begin
            held_cnt_reg <= held_cnt_next;
            held_dig_reg <= held_dig_next;
        end
    end

endmodule

>>> design/urlpc_queue.sv
// Short job queue between the front end and the output sequencer.
module urlpc_queue
    import urlpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  urlpc_job_t wr_data,
    input  logic       rd_en,
    output urlpc_job_t rd_data,
    output logic       full,
    output logic       nonempty
);

    urlpc_job_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QCNT_W-1:0]     cnt_reg;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> design/urlpc_back.sv
// Output sequencer: holds one job and presents its bytes one per transfer.
module urlpc_back
    import urlpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_nonempty,
    input  urlpc_job_t q_data,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    urlpc_job_t job_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       at_end;
    logic       take;

    assign at_end     = (idx_reg == job_reg.last_idx);
    assign empty      = !valid_reg;
    assign out_byte   = job_reg.data[idx_reg];
    assign run_last   = at_end;
    assign string_end = at_end && job_reg.str_last;

    assign take  = !valid_reg || (pop && at_end);
    assign q_pop = take && q_nonempty;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            valid_reg <= q_nonempty;
            idx_reg   <= '0;
        end
        else if (pop)
            idx_reg <= idx_reg + 2'd1;
    end

endmodule

>>> design/url_percent_codec_top.sv
// Top level of the streaming URL percent encoder/decoder.
//
// Input channel: in_byte/string_last, transferred when push is high and full
// is low. Output channel: out_byte/run_last/string_end, valid while empty is
// low, transferred when pop is high. cfg_wr_en/cfg_wr_data write codec_mode
// (0 decode, 1 encode all but alphanumerics, 2 encode keeping the path-safe
// set) and drop any held escape bytes; write only while the block is idle.
//
// With the output side free, the first result of an item is registered
// first into the job queue and then into the output sequencer before it
// shows on the output. Each input byte makes zero to three results: three for
// an escaped byte in encode mode, one for a copied one. While the receiver
// pops, the output side moves one result per cycle.
// A four-entry job queue between the classifier and the output sequencer
// lets input keep flowing while a multi-byte result drains.
//
// Reset clears the mode to decode, the held escape state and the queue.
// When the receiver stalls, the current result holds; once the queue fills,
// full rises and input transfers stop.
module url_percent_codec_top
    import urlpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    logic       q_push;
    logic       q_pop;
    logic       q_nonempty;
    urlpc_job_t q_wdata;
    urlpc_job_t q_rdata;

    urlpc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .q_full      (full),
        .in_byte     (in_byte),
        .string_last (string_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    urlpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wdata),
        .rd_en    (q_pop),
        .rd_data  (q_rdata),
        .full     (full),
        .nonempty (q_nonempty)
    );

    urlpc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

>>> design/urlpc_checker.sv
// Port-level checker for the URL percent codec, bound to the top level.
module urlpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_end
);

    // the end of a string is always the end of its item's run
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && string_end) |-> run_last)
        else $error("string_end without run_last");

    // a run in progress keeps the output occupied after each transfer
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !run_last) |=> !empty)
        else $error("output emptied in the middle of a run");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_last)
                              && $stable(string_end)))
        else $error("stalled result changed");

endmodule

bind url_percent_codec_top urlpc_checker u_urlpc_checker (.*);
